@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the dq current controller.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while the synchronous reset is low.
`define DQPI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define DQPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/dqpi_pkg.sv @@
// Package of the dq current controller: widths, register indexes, shared types
// and the 32-bit saturation function. Depends on nothing.
package dqpi_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned GAIN_W = 31;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned QSHIFT = 16;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned WIDE_W = 50;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [2:0] REG_INV_PROP_GAIN = 3'd2;
  localparam logic [2:0] REG_INDUCTANCE    = 3'd3;
  localparam logic [2:0] REG_ELEC_SPEED    = 3'd4;
  localparam logic [2:0] REG_VOLT_LIMIT    = 3'd5;

  // Reset value of the proportional and inverse proportional gains and of the limit: 1.0 in Q16.16.
  localparam logic [GAIN_W-1:0] UNITY_Q16 = 31'd65536;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t SAT_HI = 50'sd2147483647;
  localparam wide_t SAT_LO = -50'sd2147483648;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] inv_prop_gain;
    logic [GAIN_W-1:0] inductance;
    q16_t              electrical_speed;
    logic [GAIN_W-1:0] voltage_limit;
  } cfg_regs_t;

  typedef struct packed {
    q16_t op_a;
    q16_t op_b;
    logic negate;
  } mul_req_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic q16_t sat32(input wide_t v);
    if (v > SAT_HI) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < SAT_LO) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return q16_t'(v[DATA_W-1:0]);
  endfunction

endpackage

@@ rtl/dqpi_if.sv @@
// Handshake interfaces of the dq current controller: the current channel and
// the voltage channel. Depends on dqpi_pkg.
interface dqpi_in_if;
  import dqpi_pkg::*;

  logic valid;
  logic ready;
  q16_t ref_d;
  q16_t ref_q;
  q16_t meas_d;
  q16_t meas_q;

  modport source (output valid, output ref_d, output ref_q, output meas_d, output meas_q,
                  input ready);
  modport sink (input valid, input ref_d, input ref_q, input meas_d, input meas_q,
                output ready);
endinterface

interface dqpi_out_if;
  import dqpi_pkg::*;

  logic valid;
  logic ready;
  q16_t volt_d;
  q16_t volt_q;

  modport source (output valid, output volt_d, output volt_q, input ready);
  modport sink (input valid, input volt_d, input volt_q, output ready);
endinterface

@@ rtl/dq_current_pi_controller_unit.sv @@
// dq current PI controller with decoupling feed-forward and back-calculation
// anti-windup, in signed Q16.16. One transaction on in_ch is taken when the
// block is idle. One shared multiplier is then stepped through the setup states
// WL_ISS and WL_CAP and per axis through FF_ISS to CORR_CAP, and DONE moves
// the result into the output register, from which the voltage transaction is
// offered on out_ch. The block is ready again in that same cycle, so it takes
// a new current transaction only once the last result has reached the output
// register. The length of a transaction is set by the number of products (one
// wL, and per axis feed-forward, proportional, integral and correction terms)
// passing one at a time through the registered multiplier. A finished result
// is held in its own output register, so the next item may start while it
// waits; that item then holds in its final step until the waiting result has
// been taken. Depends on dqpi_pkg, dqpi_if, dqpi_regs and dqpi_mul.
module dq_current_pi_controller_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  dqpi_in_if.sink                     in_ch,
  dqpi_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dqpi_pkg::ADDR_W-1:0] paddr,
  input  logic [dqpi_pkg::DATA_W-1:0] pwdata,
  output logic [dqpi_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import dqpi_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_WL_ISS   = 4'd1;
  localparam logic [3:0] ST_WL_CAP   = 4'd2;
  localparam logic [3:0] ST_FF_ISS   = 4'd3;
  localparam logic [3:0] ST_FF_CAP   = 4'd4;
  localparam logic [3:0] ST_UP_CAP   = 4'd5;
  localparam logic [3:0] ST_UI_CAP   = 4'd6;
  localparam logic [3:0] ST_SUM      = 4'd7;
  localparam logic [3:0] ST_CLAMP    = 4'd8;
  localparam logic [3:0] ST_CORR_ISS = 4'd9;
  localparam logic [3:0] ST_CORR_CAP = 4'd10;
  localparam logic [3:0] ST_DONE     = 4'd11;

  cfg_regs_t cfg;
  mul_req_t  mreq;
  q16_t      mres;

  logic [3:0] state_r, state_nxt;
  logic       axis_r, axis_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_take, out_load;

  q16_t err_d_r, err_q_r, meas_d_r, meas_q_r;
  q16_t wl_r, ff_r, up_r, ui_r, upre_r, diff_r;
  q16_t volt_d_r, volt_q_r, res_d_r, res_q_r;
  q16_t integ_d_r, integ_q_r;

  q16_t err_sel, integ_sel, meas_other;
  q16_t vlim_pos, vlim_neg, usat;

  dqpi_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dqpi_mul u_mul (
    .clk (clk),
    .req (mreq),
    .res (mres)
  );

  // Handshake signals.
  assign in_take      = in_ch.valid && (state_r == ST_IDLE);
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.volt_d = res_d_r;
  assign out_ch.volt_q = res_q_r;

  // Per-axis operand selection: axis 0 is d, axis 1 is q.
  assign err_sel    = axis_r ? err_q_r : err_d_r;
  assign integ_sel  = axis_r ? integ_q_r : integ_d_r;
  assign meas_other = axis_r ? meas_d_r : meas_q_r;

  // Clamp of the unclamped sum to the symmetric voltage limit.
  assign vlim_pos = q16_t'({1'b0, cfg.voltage_limit});
  assign vlim_neg = -vlim_pos;
  always_comb begin
    if (upre_r > vlim_pos) begin
      usat = vlim_pos;
    end else if (upre_r < vlim_neg) begin
      usat = vlim_neg;
    end else begin
      usat = upre_r;
    end
  end

  // Operands for the shared multiplier in each step.
  always_comb begin
    mreq = '0;
    unique case (state_r)
      ST_WL_ISS: begin
        mreq.op_a = cfg.electrical_speed;
        mreq.op_b = q16_t'({1'b0, cfg.inductance});
      end
      ST_FF_ISS: begin
        mreq.op_a   = wl_r;
        mreq.op_b   = meas_other;
        mreq.negate = !axis_r;
      end
      ST_FF_CAP: begin
        mreq.op_a = q16_t'({1'b0, cfg.prop_gain});
        mreq.op_b = err_sel;
      end
      ST_UP_CAP: begin
        mreq.op_a = q16_t'({1'b0, cfg.integ_gain});
        mreq.op_b = err_sel;
      end
      ST_CORR_ISS: begin
        mreq.op_a = q16_t'({1'b0, cfg.inv_prop_gain});
        mreq.op_b = diff_r;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_WL_ISS;
          axis_nxt  = 1'b0;
        end
      end
      ST_WL_ISS:   state_nxt = ST_WL_CAP;
      ST_WL_CAP:   state_nxt = ST_FF_ISS;
      ST_FF_ISS:   state_nxt = ST_FF_CAP;
      ST_FF_CAP:   state_nxt = ST_UP_CAP;
      ST_UP_CAP:   state_nxt = ST_UI_CAP;
      ST_UI_CAP:   state_nxt = ST_SUM;
      ST_SUM:      state_nxt = ST_CLAMP;
      ST_CLAMP:    state_nxt = ST_CORR_ISS;
      ST_CORR_ISS: state_nxt = ST_CORR_CAP;
      ST_CORR_CAP: begin
        if (axis_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_FF_ISS;
          axis_nxt  = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and the two integrators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
      integ_d_r   <= '0;
      integ_q_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_CORR_CAP) begin
        if (axis_r) begin
          integ_q_r <= sat32(wide_t'(ui_r) + wide_t'(mres));
        end else begin
          integ_d_r <= sat32(wide_t'(ui_r) + wide_t'(mres));
        end
      end
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    if (in_take) begin
      err_d_r  <= sat32(wide_t'(in_ch.ref_d) - wide_t'(in_ch.meas_d));
      err_q_r  <= sat32(wide_t'(in_ch.ref_q) - wide_t'(in_ch.meas_q));
      meas_d_r <= in_ch.meas_d;
      meas_q_r <= in_ch.meas_q;
    end
    unique case (state_r)
      ST_WL_CAP: wl_r <= mres;
      ST_FF_CAP: ff_r <= mres;
      ST_UP_CAP: up_r <= mres;
      ST_UI_CAP: ui_r <= sat32(wide_t'(integ_sel) + wide_t'(mres));
      ST_SUM:    upre_r <= sat32(wide_t'(up_r) + wide_t'(ui_r) + wide_t'(ff_r));
      ST_CLAMP: begin
        diff_r <= sat32(wide_t'(usat) - wide_t'(upre_r));
        if (axis_r) begin
          volt_q_r <= usat;
        end else begin
          volt_d_r <= usat;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      res_d_r <= volt_d_r;
      res_q_r <= volt_q_r;
    end
  end

endmodule

@@ rtl/dqpi_regs.sv @@
// APB-style configuration registers of the dq current controller.
// Depends on dqpi_pkg.
module dqpi_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dqpi_pkg::ADDR_W-1:0] paddr,
  input  logic [dqpi_pkg::DATA_W-1:0] pwdata,
  output logic [dqpi_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output dqpi_pkg::cfg_regs_t         cfg
);
  import dqpi_pkg::*;

  cfg_regs_t  cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Register writes complete in the access phase; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain        <= UNITY_Q16;
      cfg_r.integ_gain       <= '0;
      cfg_r.inv_prop_gain    <= UNITY_Q16;
      cfg_r.inductance       <= '0;
      cfg_r.electrical_speed <= '0;
      cfg_r.voltage_limit    <= UNITY_Q16;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PROP_GAIN:     cfg_r.prop_gain        <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:    cfg_r.integ_gain       <= pwdata[GAIN_W-1:0];
        REG_INV_PROP_GAIN: cfg_r.inv_prop_gain    <= pwdata[GAIN_W-1:0];
        REG_INDUCTANCE:    cfg_r.inductance       <= pwdata[GAIN_W-1:0];
        REG_ELEC_SPEED:    cfg_r.electrical_speed <= q16_t'(pwdata);
        REG_VOLT_LIMIT:    cfg_r.voltage_limit    <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (reg_idx)
      REG_PROP_GAIN:     prdata = {1'b0, cfg_r.prop_gain};
      REG_INTEG_GAIN:    prdata = {1'b0, cfg_r.integ_gain};
      REG_INV_PROP_GAIN: prdata = {1'b0, cfg_r.inv_prop_gain};
      REG_INDUCTANCE:    prdata = {1'b0, cfg_r.inductance};
      REG_ELEC_SPEED:    prdata = cfg_r.electrical_speed;
      REG_VOLT_LIMIT:    prdata = {1'b0, cfg_r.voltage_limit};
      default:           prdata = '0;
    endcase
  end

endmodule

@@ rtl/dqpi_mul.sv @@
// Shared Q16.16 multiplier of the dq current controller: a registered 32 by 32
// signed product, then rescaling, optional negation and saturation. Depends on dqpi_pkg.
module dqpi_mul (
  input  logic               clk,
  input  dqpi_pkg::mul_req_t req,
  output dqpi_pkg::q16_t     res
);
  import dqpi_pkg::*;

  logic signed [PROD_W-1:0]        prod_r;
  logic                            negate_r;
  logic signed [PROD_W-QSHIFT-1:0] resc;
  wide_t                           resc_w;

  // The product is registered before it is rescaled.
  always_ff @(posedge clk) begin
    prod_r   <= $signed(req.op_a) * $signed(req.op_b);
    negate_r <= req.negate;
  end

  // Dropping the low 16 bits of a signed value rounds toward minus infinity.
  assign resc   = prod_r[PROD_W-1:QSHIFT];
  assign resc_w = wide_t'(resc);
  assign res    = sat32(negate_r ? -resc_w : resc_w);

endmodule

@@ rtl/dqpi_checker.sv @@
// Port-level checker of the dq current controller and its bind to the top level.
// Depends on assert_macros.svh and dqpi_pkg.
`include "assert_macros.svh"
module dqpi_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dqpi_pkg::DATA_W-1:0] volt_d,
  input logic [dqpi_pkg::DATA_W-1:0] volt_q,
  input logic                        pready
);

  // A stalled result transaction stays offered with its payload unchanged.
  `DQPI_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `DQPI_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(volt_d) && $stable(volt_q), "result changed under stall")

  // The block works on one item at a time and needs many cycles for it.
  `DQPI_ASSERT(a_busy_after_take, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready after accept")
  `DQPI_ASSERT(a_no_early_result, clk, rst_n, in_valid && in_ready && !out_valid |=> !out_valid, "result too early")

  // The configuration port never inserts wait states.
  `DQPI_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready low")

endmodule

bind dq_current_pi_controller_unit dqpi_checker u_dqpi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .volt_d    (out_ch.volt_d),
  .volt_q    (out_ch.volt_q),
  .pready    (pready)
);
